// ===== hw/rtl/mvm_pkg.sv =====
`timescale 1ns / 1ps

package mvm_pkg;

    localparam int MAX_SIZE  = 16;
    localparam int IDX_W     = $clog2(MAX_SIZE);
    localparam int SIZE_W    = 5;
    localparam int VALUE_W   = 16;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int SUM_W     = 40;
    localparam int MAT_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

    typedef enum logic [1:0] {
        CMD_MATRIX  = 2'd0,
        CMD_VECTOR  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

endpackage

// ===== hw/rtl/mvm_item_if.sv =====
`timescale 1ns / 1ps

interface mvm_item_if;

    logic                                valid;
    logic                                ready;
    logic [1:0]                          command;
    logic [mvm_pkg::IDX_W-1:0]           row_index;
    logic [mvm_pkg::IDX_W-1:0]           column_index;
    logic signed [mvm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, command, row_index, column_index, value, input ready);
    modport sink   (input valid, command, row_index, column_index, value, output ready);

endinterface

// ===== hw/rtl/mvm_result_if.sv =====
`timescale 1ns / 1ps

interface mvm_result_if;

    logic                              valid;
    logic                              ready;
    logic [mvm_pkg::IDX_W-1:0]         result_row;
    logic signed [mvm_pkg::SUM_W-1:0]  sum;
    logic                              last;

    modport source (output valid, result_row, sum, last, input ready);
    modport sink   (input valid, result_row, sum, last, output ready);

endinterface

// ===== hw/rtl/mvm_ram.sv =====
`timescale 1ns / 1ps

module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/matrix_vector_multiply.sv =====
// load words (matrix or vector entry) are taken one per cycle while no compute runs, no result
// a compute word of order n emits rows 0 to n-1; each row issues n reads, and its
// products pass through the multiply and accumulate stages into the output word
// one memory read port per store sets the rate; a row waits while the output word is held
// reset: size_reg is 16, no compute runs, output empty; stores are not cleared
`timescale 1ns / 1ps

module matrix_vector_multiply (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mvm_pkg::SIZE_W-1:0]   cfg_data,
    mvm_item_if.sink                     item,
    mvm_result_if.source                 result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t                              state_reg;
    logic [mvm_pkg::SIZE_W-1:0]          size_reg;
    logic [mvm_pkg::IDX_W-1:0]           row_reg;
    logic [mvm_pkg::IDX_W-1:0]           col_reg;
    logic                                rd_pending_reg;
    logic                                rd_last_reg;
    logic                                prod_valid_reg;
    logic                                prod_last_reg;
    logic signed [mvm_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mvm_pkg::SUM_W-1:0]    acc_reg;
    logic                                out_valid_reg;
    logic [mvm_pkg::IDX_W-1:0]           out_row_reg;
    logic signed [mvm_pkg::SUM_W-1:0]    out_sum_reg;
    logic                                out_last_reg;

    logic [mvm_pkg::SIZE_W-1:0]          n_eff;
    logic                                accept;
    logic                                row_ok;
    logic                                col_ok;
    logic                                mat_we;
    logic                                vec_we;
    logic [mvm_pkg::MAT_AW-1:0]          mat_raddr;
    logic [mvm_pkg::VALUE_W-1:0]         mat_rdata;
    logic [mvm_pkg::VALUE_W-1:0]         vec_rdata;
    logic signed [mvm_pkg::SUM_W-1:0]    sum_next;
    logic                                out_free;
    logic                                row_done;
    logic                                col_last;
    logic                                row_last;

    assign n_eff = (size_reg > mvm_pkg::SIZE_W'(mvm_pkg::MAX_SIZE))
                 ? mvm_pkg::SIZE_W'(mvm_pkg::MAX_SIZE) : size_reg;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign row_ok     = mvm_pkg::SIZE_W'(item.row_index) < n_eff;
    assign col_ok     = mvm_pkg::SIZE_W'(item.column_index) < n_eff;

    always_comb
    begin
        mat_we = 1'b0;
        vec_we = 1'b0;
        if (accept)
        begin
            unique case (mvm_pkg::cmd_t'(item.command))
                mvm_pkg::CMD_MATRIX: mat_we = row_ok && col_ok;
                mvm_pkg::CMD_VECTOR: vec_we = row_ok;
                default:             ;
            endcase
        end
    end

    assign mat_raddr = {row_reg, col_reg};

    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_W),
        .DEPTH (mvm_pkg::MAT_DEPTH)
    ) u_matrix_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr ({item.row_index, item.column_index}),
        .wdata (item.value),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_W),
        .DEPTH (mvm_pkg::MAX_SIZE)
    ) u_vector_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (item.row_index),
        .wdata (item.value),
        .raddr (col_reg),
        .rdata (vec_rdata)
    );

    assign sum_next = acc_reg + mvm_pkg::SUM_W'(prod_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign row_done = prod_valid_reg && prod_last_reg && out_free;
    assign col_last = (mvm_pkg::SIZE_W'(col_reg) + mvm_pkg::SIZE_W'(1)) == n_eff;
    assign row_last = (mvm_pkg::SIZE_W'(row_reg) + mvm_pkg::SIZE_W'(1)) == n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= mvm_pkg::SIZE_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            rd_pending_reg <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end

            rd_pending_reg <= (state_reg == ST_ISSUE);
            rd_last_reg    <= col_last;

            if (rd_pending_reg)
            begin
                prod_reg       <= mvm_pkg::PROD_W'($signed(mat_rdata))
                                * mvm_pkg::PROD_W'($signed(vec_rdata));
                prod_valid_reg <= 1'b1;
                prod_last_reg  <= rd_last_reg;
            end
            else if (prod_valid_reg && (!prod_last_reg || out_free))
            begin
                prod_valid_reg <= 1'b0;
            end

            if (prod_valid_reg && !prod_last_reg)
            begin
                acc_reg <= sum_next;
            end

            if (row_done)
            begin
                out_valid_reg <= 1'b1;
                out_row_reg   <= row_reg;
                out_sum_reg   <= sum_next;
                out_last_reg  <= row_last;
                acc_reg       <= '0;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (mvm_pkg::cmd_t'(item.command) == mvm_pkg::CMD_COMPUTE)
                        && (n_eff != '0))
                    begin
                        state_reg <= ST_ISSUE;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        acc_reg   <= '0;
                    end
                end
                ST_ISSUE:
                begin
                    col_reg <= col_reg + 1'b1;
                    if (col_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (row_done)
                    begin
                        col_reg <= '0;
                        if (row_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.result_row = out_row_reg;
    assign result.sum        = out_sum_reg;
    assign result.last       = out_last_reg;

endmodule

// ===== hw/rtl/mvm_checker.sv =====
`timescale 1ns / 1ps

module mvm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [mvm_pkg::IDX_W-1:0]         out_row,
    input  logic signed [mvm_pkg::SUM_W-1:0]  out_sum,
    input  logic                              out_last
);

    logic out_take;

    assign out_take = out_valid && out_ready;

    // held word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_sum)
                                    && $stable(out_last))
        else $error("output word changed while stalled");

    // no new word taken while a compute still has rows to send
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !out_last |-> !in_ready)
        else $error("input ready during compute");

    // rows come in order
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !out_last |=> !out_valid
                                  || (out_row == mvm_pkg::IDX_W'($past(out_row) + 1'b1)))
        else $error("result rows out of order");

    // after the last row the next word starts a new compute at row zero
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && out_last |=> !out_valid || (out_row == '0))
        else $error("word after last row is not row zero");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_row   (result.result_row),
    .out_sum   (result.sum),
    .out_last  (result.last)
);
